FILE: rtl/rbec_pkg.sv
// ----------------------------------------------------------------------------
// rbec_pkg: shared types and helpers for the raster boundary edge counter
// Cell classes, the front-to-back queue entry and the edge scoring functions.
// ----------------------------------------------------------------------------
package rbec_pkg;

	localparam int TOTAL_W     = 26;
	localparam int ADD_W       = 4;	// per-cell edge count, 0..4
	localparam int QUEUE_DEPTH = 4;
	localparam int REG_W       = 32;

	localparam logic [15:0] BG_CODE = 16'hFC22;	// -990

	// register byte offsets, decoded on paddr[2]
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	typedef enum logic [1:0] {
		CLS_OUT = 2'd0,
		CLS_IN  = 2'd1,
		CLS_BG  = 2'd2
	} cell_class_t;

	typedef struct packed {
		logic [ADD_W-1:0] add;
		logic             frame_end;
	} edge_entry_t;

	function automatic cell_class_t classify(logic [15:0] v);
		cell_class_t c;
		if (!v[15]) begin
			c = CLS_IN;
		end else if (v == BG_CODE) begin
			c = CLS_BG;
		end else begin
			c = CLS_OUT;
		end
		return c;
	endfunction

	// does a cell of class a score an edge against neighbor class b
	function automatic logic one_side(cell_class_t a, cell_class_t b);
		return ((a == CLS_BG) && (b != CLS_BG)) || ((a == CLS_IN) && (b == CLS_OUT));
	endfunction

	function automatic logic [1:0] pair_score(cell_class_t a, cell_class_t b);
		return {1'b0, one_side(a, b)} + {1'b0, one_side(b, a)};
	endfunction

endpackage

FILE: rtl/rbec_front.sv
// ----------------------------------------------------------------------------
// rbec_front: cell intake and classification
// Tracks raster position, keeps the row buffer of classes and scores each cell.
// ----------------------------------------------------------------------------
module rbec_front #(
	parameter int MAX_COLUMNS = 2048,
	parameter int MAX_ROWS    = 4096,
	localparam int CW = $clog2(MAX_COLUMNS),
	localparam int RW = $clog2(MAX_ROWS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,	// [15:0] cell_value
	input  logic [RW-1:0]        row_last,
	input  logic [CW-1:0]        col_last,
	output logic                 push,
	output rbec_pkg::edge_entry_t push_entry,
	input  logic                 q_full
);

	rbec_pkg::cell_class_t upper_mem [MAX_COLUMNS];
	rbec_pkg::cell_class_t upper_q;
	rbec_pkg::cell_class_t left_q;
	logic [RW-1:0]         row_q;
	logic [CW-1:0]         col_q;

	logic                  valid_s1;
	rbec_pkg::cell_class_t cls_s1;
	logic [2:0]            part_s1;
	logic                  upper_en_s1;
	logic                  end_s1;

	logic                  accept;
	rbec_pkg::cell_class_t cls;
	logic                  last_r;
	logic                  last_c;
	logic [2:0]            border;
	logic [1:0]            left_add;
	logic [1:0]            upper_add;

	assign accept   = s_tvalid && s_tready;
	assign push     = valid_s1 && !q_full;
	assign s_tready = !valid_s1 || !q_full;

	assign cls    = rbec_pkg::classify(s_tdata);
	assign last_r = (row_q >= row_last);
	assign last_c = (col_q >= col_last);

	always_comb begin
		border = '0;
		if (cls != rbec_pkg::CLS_OUT) begin
			border = 3'(row_q == '0) + 3'(col_q == '0) + 3'(last_r) + 3'(last_c);
		end
		left_add = (col_q != '0) ? rbec_pkg::pair_score(left_q, cls) : 2'd0;
	end

	// row buffer: read-first, so the read sees the previous row's class
	always_ff @(posedge clk) begin
		if (accept) begin
			upper_q        <= upper_mem[col_q];
			upper_mem[col_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= rbec_pkg::CLS_OUT;
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				left_q   <= cls;
				if (last_c) begin
					col_q <= '0;
					row_q <= last_r ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cls_s1      <= cls;
			part_s1     <= border + {1'b0, left_add};
			upper_en_s1 <= (row_q != '0);
			end_s1      <= last_r && last_c;
		end
	end

	assign upper_add = upper_en_s1 ? rbec_pkg::pair_score(upper_q, cls_s1) : 2'd0;

	always_comb begin
		push_entry.add       = {1'b0, part_s1} + {2'b00, upper_add};
		push_entry.frame_end = end_s1;
	end

endmodule

FILE: rtl/rbec_queue.sv
// ----------------------------------------------------------------------------
// rbec_queue: short FIFO of scored cells
// Decouples the intake side from the accumulator and result register.
// ----------------------------------------------------------------------------
module rbec_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rbec_pkg::edge_entry_t push_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  q_valid,
	output rbec_pkg::edge_entry_t head
);

	localparam int PW = $clog2(rbec_pkg::QUEUE_DEPTH);

	rbec_pkg::edge_entry_t slots_q [rbec_pkg::QUEUE_DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [PW:0]           count_q;

	assign full    = (count_q == (PW+1)'(rbec_pkg::QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign head    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/rbec_back.sv
// ----------------------------------------------------------------------------
// rbec_back: edge accumulator and result register
// Sums per-cell counts with saturation and posts the frame total.
// ----------------------------------------------------------------------------
module rbec_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  rbec_pkg::edge_entry_t         head,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rbec_pkg::TOTAL_W-1:0]  total
);

	logic [rbec_pkg::TOTAL_W-1:0] acc_q;
	logic [rbec_pkg::TOTAL_W-1:0] total_q;
	logic                         out_valid_q;
	logic [rbec_pkg::TOTAL_W:0]   sum;
	logic [rbec_pkg::TOTAL_W-1:0] sat;
	logic                         post;

	assign pop  = q_valid && (!head.frame_end || !out_valid_q || m_tready);
	assign post = pop && head.frame_end;
	assign sum  = {1'b0, acc_q} + (rbec_pkg::TOTAL_W+1)'(head.add);
	assign sat  = sum[rbec_pkg::TOTAL_W] ? '1 : sum[rbec_pkg::TOTAL_W-1:0];

	assign m_tvalid = out_valid_q;
	assign total    = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q <= head.frame_end ? '0 : sat;
			end
			if (post) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (post) begin
			total_q <= sat;
		end
	end

endmodule

FILE: rtl/raster_boundary_edge_count.sv
// ----------------------------------------------------------------------------
// raster_boundary_edge_count: 4-neighbor boundary edge counter for a raster
// Counts class boundary edges over a row-major stream of 16-bit class codes.
// ----------------------------------------------------------------------------
// Cells stream in row-major order, one beat per cell, and the block takes one
// cell every clock while the queue is not full: the only per-cell work is a
// read and a write of the column-indexed row buffer in the same cycle plus a
// few compares. A cell's count is registered in the front end, written into
// the queue and added to the running sum when it is popped; the frame total
// is then registered on the output and holds until taken.
// A four-entry queue sits between the scoring
// front end and the accumulator, so a stalled result only stops the input
// once the queue fills, and the accumulator keeps absorbing cells of the
// next frame while the previous total waits. Frame size comes from
// row_count (offset 0x0) and column_count (offset 0x4); a zero acts as one
// and values above MAX_ROWS / MAX_COLUMNS are clamped. Change them only
// between frames. The total saturates at 2^26-1. The row buffer needs no
// clearing after reset: the first row ignores what it reads.
// ----------------------------------------------------------------------------
module raster_boundary_edge_count #(
	parameter int MAX_COLUMNS = 2048,
	parameter int MAX_ROWS    = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// cell stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,	// [15:0] cell_value
	// frame total out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,	// [25:0] boundary_length, [31:26] zero
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int RW = $clog2(MAX_ROWS);

	logic [12:0]                  row_count_q;
	logic [11:0]                  column_count_q;
	logic [RW-1:0]                row_last;
	logic [CW-1:0]                col_last;
	logic                         wr_en;

	logic                         push;
	rbec_pkg::edge_entry_t        push_entry;
	logic                         q_full;
	logic                         pop;
	logic                         q_valid;
	rbec_pkg::edge_entry_t        head;
	logic [rbec_pkg::TOTAL_W-1:0] total;

	// register write on the access beat; pready is tied high
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= 13'd256;
			column_count_q <= 12'd256;
		end else if (wr_en) begin
			unique case (paddr[2])
				rbec_pkg::REG_ROW_COUNT:    row_count_q    <= pwdata[12:0];
				rbec_pkg::REG_COLUMN_COUNT: column_count_q <= pwdata[11:0];
				default:                    row_count_q    <= row_count_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rbec_pkg::REG_ROW_COUNT:    prdata = {19'd0, row_count_q};
			rbec_pkg::REG_COLUMN_COUNT: prdata = {20'd0, column_count_q};
			default:                    prdata = '0;
		endcase
	end

	// last row / column index after clamping to 1..MAX
	always_comb begin
		if (row_count_q == '0) begin
			row_last = '0;
		end else if (32'(row_count_q) > 32'(MAX_ROWS)) begin
			row_last = RW'(MAX_ROWS - 1);
		end else begin
			row_last = RW'(row_count_q - 13'd1);
		end
		if (column_count_q == '0) begin
			col_last = '0;
		end else if (32'(column_count_q) > 32'(MAX_COLUMNS)) begin
			col_last = CW'(MAX_COLUMNS - 1);
		end else begin
			col_last = CW'(column_count_q - 12'd1);
		end
	end

	// front end: position tracking, row buffer, per-cell score
	rbec_front #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.row_last   (row_last),
		.col_last   (col_last),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	rbec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.q_valid    (q_valid),
		.head       (head)
	);

	// back end: saturating sum and result register
	rbec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.total    (total)
	);

	assign m_tdata = {6'd0, total};

endmodule

FILE: rtl/rbec_checker.sv
// ----------------------------------------------------------------------------
// rbec_checker: port-level checks for the raster boundary edge counter
// Watches the result stream and the register port over time.
// ----------------------------------------------------------------------------
module rbec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic        pready,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// a waiting total holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// the total never exceeds 26 bits
	a_out_width: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:26] == 6'd0))
		else $error("result carries bits above 26");

	// a row_count write reads back on the next cycle
	a_row_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && !paddr[2]) ##1
		(!paddr[2] && !(psel && penable && pwrite))
		|-> (prdata == {19'd0, $past(pwdata[12:0])}))
		else $error("row_count readback mismatch");

	// a column_count write reads back on the next cycle
	a_col_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[2]) ##1
		(paddr[2] && !(psel && penable && pwrite))
		|-> (prdata == {20'd0, $past(pwdata[11:0])}))
		else $error("column_count readback mismatch");

endmodule

bind raster_boundary_edge_count rbec_checker u_rbec_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.pready   (pready),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);
